// ===== hdl/alm_pkg.sv =====
// shared constants for the approximate logarithmic multiplier
// no dependencies
`default_nettype none

package alm_pkg;

   localparam int DEFAULT_OPERAND_WIDTH = 16;
   localparam int FIELD_WIDTH           = 16;
   localparam int PRODUCT_WIDTH         = 31;
   localparam int KEPT_WIDTH            = 5;
   localparam int KEPT_BITS_RESET       = 4;
   localparam int KEPT_BITS_MIN         = 2;

endpackage

`default_nettype wire

// ===== hdl/approx_log_multiplier_16.sv =====
// approximate signed logarithmic multiplier with dynamic-range truncation
// depends on alm_pkg and alm_operand
// a req beat is held in the input register, then the product in product_ff for rsp
// one beat per cycle unless rsp stalls; input register fills while a result waits
// reset: synchronous, clears both valid flags and sets kept_bits to four
`default_nettype none

module approx_log_multiplier_16
   import alm_pkg::*;
#(
   parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [31:0]           req_tdata,   // operand_a[15:0], operand_b[31:16]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [31:0]                rsp_tdata,   // product[30:0], zero pad[31]
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [KEPT_WIDTH-1:0] csr_data     // kept_bits
);

   localparam int OPW = OPERAND_WIDTH;
   localparam int KW  = $clog2(OPW);
   localparam int PW  = (2 * OPW > PRODUCT_WIDTH) ? 2 * OPW : PRODUCT_WIDTH;

   logic                          s1_valid_ff, s1_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [FIELD_WIDTH-1:0] a_ff, b_ff;
   logic [PRODUCT_WIDTH-1:0]      product_ff, product_in;
   logic [OPW-2:0]                forced_ff, forced_in;
   logic                          out_load;
   logic                          req_beat;

   logic           neg_a, neg_b, zero_a, zero_b;
   logic [KW-1:0]  lead_a, lead_b;
   logic [OPW-2:0] frac_a, frac_b;
   logic [OPW:0]   sum;
   logic [KW:0]    lead_p;
   logic [3*OPW-1:0] full;
   logic [PW-1:0]  mag_p, signed_p;

   assign csr_ready = 1'b1;

   always_comb begin
      int wc;
      wc = int'(csr_data);
      if (wc < KEPT_BITS_MIN) begin
         wc = KEPT_BITS_MIN;
      end
      if (wc > OPW) begin
         wc = OPW;
      end
      forced_in = (OPW-1)'(1) << (OPW - wc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forced_ff <= (OPW-1)'(1) << (OPW - KEPT_BITS_RESET);
      end else if (csr_valid && csr_ready) begin
         forced_ff <= forced_in;
      end
   end

   assign out_load    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || out_load;
   assign req_beat    = req_tvalid && req_tready;
   assign s1_valid_in = req_beat ? 1'b1 : (out_load ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = out_load ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         a_ff <= req_tdata[FIELD_WIDTH-1:0];
         b_ff <= req_tdata[2*FIELD_WIDTH-1:FIELD_WIDTH];
      end
      if (out_load && s1_valid_ff) begin
         product_ff <= product_in;
      end
   end

   alm_operand #(.OPW(OPW)) u_op_a (
      .operand (a_ff),
      .forced  (forced_ff),
      .neg     (neg_a),
      .zero    (zero_a),
      .lead    (lead_a),
      .frac    (frac_a)
   );

   alm_operand #(.OPW(OPW)) u_op_b (
      .operand (b_ff),
      .forced  (forced_ff),
      .neg     (neg_b),
      .zero    (zero_b),
      .lead    (lead_b),
      .frac    (frac_b)
   );

   // fraction sum, carry into the exponent, then linear (approximate) antilog
   assign sum      = {2'b00, frac_a} + {2'b00, frac_b} + {2'b00, forced_ff};
   assign lead_p   = {1'b0, lead_a} + {1'b0, lead_b} + {{KW{1'b0}}, sum[OPW-1]};
   assign full     = (3*OPW)'({1'b1, sum[OPW-2:0]}) << lead_p;
   assign mag_p    = PW'(full >> (OPW - 1));
   assign signed_p = (neg_a != neg_b) ? ~mag_p : mag_p;

   assign product_in = (zero_a || zero_b) ? '0 : signed_p[PRODUCT_WIDTH-1:0];

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, product_ff};

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input refused with room in the pipeline");

   a_beat_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> s1_valid_ff)
      else $error("accepted beat lost from input register");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load) |=> rsp_valid_ff)
      else $error("input register drained without a result");

   a_zero_operand: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_load && (zero_a || zero_b)) |=> (rsp_tdata == '0))
      else $error("zero magnitude operand gave nonzero product");

   a_forced_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(forced_ff))
      else $error("rounding bit mask not one-hot");

endmodule

`default_nettype wire

// ===== hdl/alm_operand.sv =====
// one operand path: one's complement magnitude, leading-one detect,
// normalised and truncated fraction; depends on alm_pkg
`default_nettype none

module alm_operand
   import alm_pkg::*;
#(
   parameter int OPW = DEFAULT_OPERAND_WIDTH,
   localparam int KW = $clog2(OPW)
) (
   input  wire logic signed [FIELD_WIDTH-1:0] operand,
   input  wire logic        [OPW-2:0]         forced,
   output logic                               neg,
   output logic                               zero,
   output logic             [KW-1:0]          lead,
   output logic             [OPW-2:0]         frac
);

   logic signed [OPW-1:0] wrapped;
   logic        [OPW-2:0] mag;
   logic        [OPW-2:0] shifted;
   logic        [KW-1:0]  shamt;

   assign wrapped = OPW'(operand);
   assign neg     = wrapped[OPW-1];
   assign mag     = neg ? ~wrapped[OPW-2:0] : wrapped[OPW-2:0];
   assign zero    = (mag == '0);

   always_comb begin
      lead = '0;
      for (int i = 0; i < OPW - 1; i++) begin
         if (mag[i]) begin
            lead = KW'(i);
         end
      end
   end

   // leading one lands just above the fraction and drops out
   assign shamt   = KW'(OPW - 1) - lead;
   assign shifted = mag << shamt;
   assign frac    = (shifted & ~(forced - (OPW-1)'(1))) | forced;

endmodule

`default_nettype wire
